FILE: hw/rtl/r2a_pkg.sv
// Shared constants, types and the digit-to-ASCII function for radix_to_ascii_digits.
package r2a_pkg;

	localparam int VALUE_BITS = 31;
	localparam int MAX_DIGITS = 32;
	localparam int RADIX_BITS = 5;
	localparam int DIGIT_BITS = 4;
	localparam int CHAR_BITS  = 7;

	// Divider works on a fixed slice of the dividend each cycle
	localparam int DIV_STEPS = 8;
	localparam int CHUNKS    = (VALUE_BITS + DIV_STEPS - 1) / DIV_STEPS;
	localparam int VAL_W     = CHUNKS * DIV_STEPS;
	localparam int CHUNK_W   = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

	localparam int ADDR_W = $clog2(MAX_DIGITS);
	localparam int CNT_W  = $clog2(MAX_DIGITS + 1);

	localparam logic [RADIX_BITS-1:0] RADIX_MIN = RADIX_BITS'(2);
	localparam logic [RADIX_BITS-1:0] RADIX_MAX = RADIX_BITS'(16);

	localparam logic [CHAR_BITS-1:0] CHAR_NEWLINE = CHAR_BITS'(10);
	localparam logic [CHAR_BITS-1:0] CHAR_NONE    = CHAR_BITS'(0);
	localparam logic [CHAR_BITS-1:0] CHAR_ZERO    = CHAR_BITS'(48);
	localparam logic [CHAR_BITS-1:0] CHAR_ALPHA   = CHAR_BITS'(55);  // 'A' - 10
	localparam logic [DIGIT_BITS-1:0] DIGIT_TEN   = DIGIT_BITS'(10);

	// One queued conversion request
	typedef struct packed {
		logic [VALUE_BITS-1:0] value;
		logic [RADIX_BITS-1:0] radix;
		logic                  bad;
	} r2a_item_t;

	function automatic logic [CHAR_BITS-1:0] ascii_of(input logic [DIGIT_BITS-1:0] d);
		logic [CHAR_BITS-1:0] ext;
		ext = CHAR_BITS'(d);
		if (d < DIGIT_TEN) begin
			return CHAR_ZERO + ext;
		end
		return CHAR_ALPHA + ext;
	endfunction

endpackage

FILE: hw/rtl/radix_to_ascii_digits.sv
// Top level of radix_to_ascii_digits: front-end queue plus divider/emitter back end.
//
// Input channel (item_valid/item_ready, value, radix) takes one integer and a base.
// Output channel (char_valid/char_ready, character, last, bad_base) returns the
// ASCII digits most significant first, then a newline with last set.
// A zero value returns only the newline. A base outside 2..16 returns a single
// item with character 0, last and bad_base set.
// A two-entry queue sits between the front end and the converter, so up to two
// items are taken while a conversion or its output is still in flight.
// Per item, a divider handles 8 dividend bits a cycle to produce each digit;
// each digit is then read from the digit store and loaded into the output
// register. The divider slice and the single read port of the digit store set
// the pace of a conversion.
// Each result is held in the output register until it is taken; a stalled
// receiver holds the register and pauses emission, while the queue keeps taking items.
// Reset (arst_n low) empties the queue and the output register and returns the
// converter to idle; the digit store is not cleared.
module radix_to_ascii_digits (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_ready,
	input  logic [r2a_pkg::VALUE_BITS-1:0] value,
	input  logic [r2a_pkg::RADIX_BITS-1:0] radix,
	output logic                           char_valid,
	input  logic                           char_ready,
	output logic [r2a_pkg::CHAR_BITS-1:0]  character,
	output logic                           last,
	output logic                           bad_base
);
	import r2a_pkg::*;

	logic      q_valid;
	logic      q_pop;
	r2a_item_t q_item;

	r2a_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.value      (value),
		.radix      (radix),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_pop      (q_pop)
	);

	r2a_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_pop      (q_pop),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.character  (character),
		.last       (last),
		.bad_base   (bad_base)
	);

endmodule

FILE: hw/rtl/r2a_front.sv
// Front end: accepts items, flags bad bases, and queues them for the converter.
module r2a_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_ready,
	input  logic [r2a_pkg::VALUE_BITS-1:0] value,
	input  logic [r2a_pkg::RADIX_BITS-1:0] radix,
	output logic                           q_valid,
	output r2a_pkg::r2a_item_t             q_item,
	input  logic                           q_pop
);
	import r2a_pkg::*;

	r2a_item_t  entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	r2a_item_t  new_item;

	// Classify the incoming item
	always_comb begin
		new_item.value = value;
		new_item.radix = radix;
		new_item.bad   = (radix < RADIX_MIN) || (radix > RADIX_MAX);
	end

	assign item_ready = (count_q != 2'd2);
	assign push       = item_valid && item_ready;
	assign q_valid    = (count_q != 2'd0);
	assign q_item     = entry_q[rd_ptr_q];

	// Store queue payload
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= new_item;
		end
	end

	// Advance queue pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, q_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Queue never overfills, never pops empty, and stays full until it is popped
	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3) else $error("queue count out of range");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid) else $error("pop from empty queue");
	a_full_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd2 && !q_pop) |=> (count_q == 2'd2)) else $error("full queue drained");

endmodule

FILE: hw/rtl/r2a_back.sv
// Back end: iterative digit divider, digit store and most-significant-first emitter.
module r2a_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	input  r2a_pkg::r2a_item_t            q_item,
	output logic                          q_pop,
	output logic                          char_valid,
	input  logic                          char_ready,
	output logic [r2a_pkg::CHAR_BITS-1:0] character,
	output logic                          last,
	output logic                          bad_base
);
	import r2a_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DIV  = 4'b0010,
		ST_EMIT = 4'b0100,
		ST_NL   = 4'b1000
	} state_t;

	state_t                 state_q;
	logic [RADIX_BITS-1:0]  radix_q;
	logic [VAL_W-1:0]       val_q;
	logic [DIGIT_BITS-1:0]  rem_q;
	logic [CHUNK_W-1:0]     chunk_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [ADDR_W-1:0]      ptr_q;
	logic [DIGIT_BITS-1:0]  rd_data_q;
	logic                   rd_pend_q;
	logic                   out_valid_q;
	logic [CHAR_BITS-1:0]   char_q;
	logic                   last_q;
	logic                   bad_q;
	logic [DIGIT_BITS-1:0]  digit_mem [MAX_DIGITS];

	logic [DIV_STEPS-1:0]   chunk_bits;
	logic [DIV_STEPS-1:0]   qbits;
	logic [RADIX_BITS-1:0]  part;
	logic [DIGIT_BITS-1:0]  rem_nxt;
	logic [VAL_W-1:0]       val_nxt;
	logic                   last_chunk;
	logic                   out_free;
	logic                   out_load;
	logic                   mem_we;
	logic                   mem_re;

	// One slice of restoring division by the radix
	always_comb begin
		chunk_bits = val_q[VAL_W-1 -: DIV_STEPS];
		part       = RADIX_BITS'(rem_q);
		qbits      = '0;
		for (int i = DIV_STEPS - 1; i >= 0; i--) begin
			part = {part[RADIX_BITS-2:0], chunk_bits[i]};
			if (part >= radix_q) begin
				part     = part - radix_q;
				qbits[i] = 1'b1;
			end
		end
		rem_nxt = part[DIGIT_BITS-1:0];
		val_nxt = {val_q[VAL_W-DIV_STEPS-1:0], qbits};
	end

	assign last_chunk = (chunk_q == CHUNK_W'(CHUNKS - 1));
	assign out_free   = !out_valid_q || char_ready;
	assign out_load   = out_free && (((state_q == ST_IDLE) && q_valid && q_item.bad)
		|| ((state_q == ST_EMIT) && rd_pend_q) || (state_q == ST_NL));
	assign mem_we     = (state_q == ST_DIV) && last_chunk;
	assign mem_re     = (state_q == ST_EMIT) && !rd_pend_q;
	assign q_pop      = (state_q == ST_IDLE) && q_valid && (!q_item.bad || out_free);

	assign char_valid = out_valid_q;
	assign character  = char_q;
	assign last       = last_q;
	assign bad_base   = bad_q;

	// Digit store: write one digit as each division ends, read one digit for each emitted character
	always_ff @(posedge clk) begin
		if (mem_we) begin
			digit_mem[cnt_q[ADDR_W-1:0]] <= rem_nxt;
		end
		if (mem_re) begin
			rd_data_q <= digit_mem[ptr_q];
		end
	end

	// Hold working payload
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (q_valid && !q_item.bad) begin
					radix_q <= q_item.radix;
					val_q   <= VAL_W'(q_item.value);
					rem_q   <= '0;
				end
			end
			ST_DIV: begin
				val_q <= val_nxt;
				rem_q <= last_chunk ? '0 : rem_nxt;
			end
			default: begin
				val_q <= val_q;
			end
		endcase
	end

	// Sequence conversion, emission and the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			chunk_q     <= '0;
			cnt_q       <= '0;
			ptr_q       <= '0;
			rd_pend_q   <= 1'b0;
			out_valid_q <= 1'b0;
			char_q      <= CHAR_NONE;
			last_q      <= 1'b0;
			bad_q       <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (char_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_valid && q_item.bad) begin
						if (out_free) begin
							char_q <= CHAR_NONE;
							last_q <= 1'b1;
							bad_q  <= 1'b1;
						end
					end else if (q_valid) begin
						chunk_q <= '0;
						cnt_q   <= '0;
						state_q <= (q_item.value == '0) ? ST_NL : ST_DIV;
					end
				end
				ST_DIV: begin
					if (last_chunk) begin
						chunk_q <= '0;
						cnt_q   <= cnt_q + CNT_W'(1);
						if (val_nxt == '0 || cnt_q == CNT_W'(MAX_DIGITS - 2)) begin
							ptr_q     <= cnt_q[ADDR_W-1:0];
							rd_pend_q <= 1'b0;
							state_q   <= ST_EMIT;
						end
					end else begin
						chunk_q <= chunk_q + CHUNK_W'(1);
					end
				end
				ST_EMIT: begin
					if (!rd_pend_q) begin
						rd_pend_q <= 1'b1;
					end else if (out_free) begin
						char_q    <= ascii_of(rd_data_q);
						last_q    <= 1'b0;
						bad_q     <= 1'b0;
						rd_pend_q <= 1'b0;
						if (ptr_q == '0) begin
							state_q <= ST_NL;
						end else begin
							ptr_q <= ptr_q - ADDR_W'(1);
						end
					end
				end
				ST_NL: begin
					if (out_free) begin
						char_q  <= CHAR_NEWLINE;
						last_q  <= 1'b1;
						bad_q   <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// A bad-base result is always the only, and so the last, item of its run
	a_bad_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && bad_q) |-> last_q) else $error("bad base item without last");
	// Digit count stays below the store depth while dividing
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (cnt_q < CNT_W'(MAX_DIGITS))) else $error("digit count overflow");
	// Queue is only drained between runs
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (state_q == ST_IDLE)) else $error("pop during a run");
	// A pending store read only exists while emitting digits
	a_pend_emit: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_q |-> (state_q == ST_EMIT)) else $error("stray store read");

endmodule
